[sv/gjmi_pkg.sv]
package gjmi_pkg;

    localparam int MAX_ORDER = 4;
    localparam int MAX_RHS   = 4;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 2;
    localparam int CNT_W     = 3;
    localparam int ADDR_W    = 2 * IDX_W + 1;

    localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [DATA_W-1:0] Q_ZERO = 32'sh0000_0000;
    localparam logic signed [DATA_W-1:0] Q_MAX  = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] Q_MIN  = 32'sh8000_0000;

    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [2:0] {
        W_LOAD,
        W_RD,
        W_TMP,
        W_PROD,
        W_DIFF
    } t_wsrc;

    typedef enum logic {
        MUL_SCALE,
        MUL_ELIM
    } t_msrc;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_PIV_LOG,
        ST_SW_RD1,
        ST_SW_RD2,
        ST_SW_WR1,
        ST_SW_WR2,
        ST_PIV_RD,
        ST_PIV_CHK,
        ST_DIV_WAIT,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_WR,
        ST_EL_ROW,
        ST_EL_FRD,
        ST_EL_FLD,
        ST_EL_RD1,
        ST_EL_RD2,
        ST_EL_WR,
        ST_UN_CHK,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_SING
    } t_state;

    typedef struct packed {
        logic  mem_we;
        t_wsrc wsrc;
        t_addr waddr;
        t_addr raddr;
        logic  tmp_ld;
        logic  srch_clr;
        logic  srch_cmp;
        logic  used_clr;
        logic  piv_commit;
        t_idx  log_idx;
        logic  div_start;
        logic  f_ld;
        logic  mul_en;
        t_msrc msrc;
        logic  one_sel;
        logic  zero_old;
        logic  out_ld;
        logic  out_which;
        t_idx  out_row;
        t_idx  out_col;
        logic  out_sing;
        logic  out_final;
    } t_cmd;

    typedef struct packed {
        t_idx pr;
        t_idx pc;
        logic big_zero;
        logic div_busy;
        t_idx log_r;
        t_idx log_c;
        logic out_free;
    } t_stat;

endpackage

[sv/gjmi_in_if.sv]
interface gjmi_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [2:0]  row;
    logic [2:0]  col;
    logic signed [31:0] value;
    logic        last;

    modport source (output valid, opcode, row, col, value, last, input ready);
    modport sink   (input valid, opcode, row, col, value, last, output ready);
endinterface

[sv/gjmi_out_if.sv]
interface gjmi_out_if;
    logic        valid;
    logic        ready;
    logic        which;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic signed [31:0] out_value;
    logic        singular;
    logic        final_res;

    modport source (output valid, which, out_row, out_col, out_value, singular, final_res,
                    input ready);
    modport sink   (input valid, which, out_row, out_col, out_value, singular, final_res,
                    output ready);
endinterface

[sv/gjmi_div.sv]
module gjmi_div
    import gjmi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_data i_den,
    output logic  o_busy,
    output t_data o_quot
);

    logic [DATA_W:0]   r_rem, n_rem;
    logic [DATA_W:0]   r_quo, n_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;
    logic [5:0]        r_cnt;
    logic [DATA_W:0]   sh;
    logic [DATA_W:0]   den_x;
    logic              ge;
    logic [DATA_W:0]   negq;

    // 2^32 / |den|, one quotient bit per cycle
    assign sh    = {r_rem[DATA_W-1:0], r_quo[DATA_W]};
    assign den_x = {1'b0, r_den};
    assign ge    = sh >= den_x;
    assign n_rem = ge ? (sh - den_x) : sh;
    assign n_quo = {r_quo[DATA_W-1:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'(DATA_W + 1);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {1'b1, {DATA_W{1'b0}}};
            r_den <= i_den[DATA_W-1] ? (~i_den + 32'd1) : i_den;
            r_neg <= i_den[DATA_W-1];
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_cnt != '0;
    assign negq   = ~r_quo + 33'd1;

    always_comb begin
        if (!r_neg) begin
            o_quot = (r_quo > {1'b0, Q_MAX}) ? Q_MAX : t_data'(r_quo[DATA_W-1:0]);
        end else begin
            o_quot = (r_quo > 33'h0_8000_0000) ? Q_MIN : t_data'(negq[DATA_W-1:0]);
        end
    end

endmodule

[sv/gjmi_dp.sv]
module gjmi_dp
    import gjmi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_stat      o_stat,
    input  logic       i_opcode,
    input  logic [2:0] i_row,
    input  logic [2:0] i_col,
    input  t_data      i_value,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic       o_which,
    output logic [2:0] o_out_row,
    output logic [2:0] o_out_col,
    output t_data      o_out_value,
    output logic       o_singular,
    output logic       o_final_res
);

    t_data r_mem [2**ADDR_W];
    t_data r_rd, r_tmp, r_f, r_prod;
    logic [DATA_W:0] r_big;
    t_idx r_pr, r_pc;
    logic [MAX_ORDER-1:0] r_used;
    t_idx r_plog [MAX_ORDER];
    t_idx r_clog [MAX_ORDER];

    logic r_o_valid, r_o_which, r_o_sing, r_o_final;
    t_idx r_o_row, r_o_col;
    t_data r_o_value;

    logic div_busy;
    t_data pinv;

    logic in_range;
    t_addr ld_addr;
    t_addr waddr;
    t_data wdata;
    logic we;
    logic [DATA_W:0] sx, mag;
    t_idx s_row, s_col;
    logic elig;
    t_data mul_a, mul_b;
    logic signed [2*DATA_W-1:0] prod, prod_sh;
    t_data prod_sat;
    t_data old;
    logic signed [DATA_W:0] diff;
    t_data diff_sat;

    gjmi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_den   (r_rd),
        .o_busy  (div_busy),
        .o_quot  (pinv)
    );

    assign in_range = (i_row < CNT_W'(MAX_ORDER)) &&
                      (i_col < (i_opcode ? CNT_W'(MAX_RHS) : CNT_W'(MAX_ORDER)));
    assign ld_addr  = {i_row[IDX_W-1:0], i_opcode, i_col[IDX_W-1:0]};

    assign sx    = {r_rd[DATA_W-1], r_rd};
    assign mag   = sx[DATA_W] ? (~sx + 33'd1) : sx;
    assign s_row = i_cmd.raddr[ADDR_W-1 -: IDX_W];
    assign s_col = i_cmd.raddr[IDX_W-1:0];
    assign elig  = !r_used[s_row] && !r_used[s_col];

    always_comb begin
        if (i_cmd.msrc == MUL_SCALE) begin
            mul_a = i_cmd.one_sel ? Q_ONE : r_rd;
            mul_b = pinv;
        end else begin
            mul_a = r_rd;
            mul_b = r_f;
        end
        prod    = mul_a * mul_b;
        prod_sh = prod >>> 16;
        if (prod_sh > 64'sd2147483647) begin
            prod_sat = Q_MAX;
        end else if (prod_sh < -64'sd2147483648) begin
            prod_sat = Q_MIN;
        end else begin
            prod_sat = t_data'(prod_sh[DATA_W-1:0]);
        end
    end

    always_comb begin
        old  = i_cmd.zero_old ? Q_ZERO : r_rd;
        diff = {old[DATA_W-1], old} - {r_prod[DATA_W-1], r_prod};
        if (diff[DATA_W] != diff[DATA_W-1]) begin
            diff_sat = diff[DATA_W] ? Q_MIN : Q_MAX;
        end else begin
            diff_sat = t_data'(diff[DATA_W-1:0]);
        end
    end

    always_comb begin
        we    = i_cmd.mem_we;
        waddr = i_cmd.waddr;
        case (i_cmd.wsrc)
            W_LOAD: begin
                we    = i_cmd.mem_we && in_range;
                waddr = ld_addr;
                wdata = i_value;
            end
            W_RD:    wdata = r_rd;
            W_TMP:   wdata = r_tmp;
            W_PROD:  wdata = r_prod;
            W_DIFF:  wdata = diff_sat;
            default: wdata = r_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[i_cmd.raddr];
        if (i_cmd.tmp_ld) begin
            r_tmp <= r_rd;
        end
        if (i_cmd.f_ld) begin
            r_f <= r_rd;
        end
        if (i_cmd.mul_en) begin
            r_prod <= prod_sat;
        end
        if (i_cmd.srch_clr) begin
            r_big <= '0;
            r_pr  <= '0;
            r_pc  <= '0;
        end else if (i_cmd.srch_cmp && elig && (mag >= r_big)) begin
            r_big <= mag;
            r_pr  <= s_row;
            r_pc  <= s_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            for (int t = 0; t < MAX_ORDER; t++) begin
                r_plog[t] <= '0;
                r_clog[t] <= '0;
            end
        end else if (i_cmd.used_clr) begin
            r_used <= '0;
        end else if (i_cmd.piv_commit) begin
            r_used[r_pc]            <= 1'b1;
            r_plog[i_cmd.log_idx]   <= r_pr;
            r_clog[i_cmd.log_idx]   <= r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_o_which <= i_cmd.out_which;
            r_o_row   <= i_cmd.out_row;
            r_o_col   <= i_cmd.out_col;
            r_o_value <= i_cmd.out_sing ? Q_ZERO : r_rd;
            r_o_sing  <= i_cmd.out_sing;
            r_o_final <= i_cmd.out_final;
        end
    end

    assign o_stat.pr       = r_pr;
    assign o_stat.pc       = r_pc;
    assign o_stat.big_zero = r_big == '0;
    assign o_stat.div_busy = div_busy;
    assign o_stat.log_r    = r_plog[i_cmd.log_idx];
    assign o_stat.log_c    = r_clog[i_cmd.log_idx];
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    assign o_out_valid = r_o_valid;
    assign o_which     = r_o_which;
    assign o_out_row   = {1'b0, r_o_row};
    assign o_out_col   = {1'b0, r_o_col};
    assign o_out_value = r_o_value;
    assign o_singular  = r_o_sing;
    assign o_final_res = r_o_final;

endmodule

[sv/gjmi_ctrl.sv]
module gjmi_ctrl
    import gjmi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_last,
    output logic       o_in_ready,
    input  logic [2:0] i_size,
    input  logic [2:0] i_rhs,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    t_idx r_step, n_step;
    t_idx r_j, n_j;
    t_idx r_k, n_k;
    logic r_sec, n_sec;
    logic r_unscr, n_unscr;
    logic r_which, n_which;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_m, n_m;

    logic [CNT_W-1:0] k_inc, j_inc, step_inc;
    logic a_last_col, row_last, step_last, col_done, out_col_last, out_done;
    t_idx col_nk;
    logic col_nsec;
    t_addr sw_a1, sw_a2, col_pc, col_j;
    logic on_pivot;

    assign k_inc      = {1'b0, r_k} + 3'd1;
    assign j_inc      = {1'b0, r_j} + 3'd1;
    assign step_inc   = {1'b0, r_step} + 3'd1;
    assign a_last_col = k_inc >= r_n;
    assign row_last   = j_inc >= r_n;
    assign step_last  = step_inc >= r_n;

    // column walk over A then B of one row
    assign col_done = r_sec ? (k_inc >= r_m) : (a_last_col && (r_m == '0));
    assign col_nsec = r_sec || a_last_col;
    assign col_nk   = (!r_sec && a_last_col) ? '0 : k_inc[IDX_W-1:0];

    assign out_col_last = r_which ? (k_inc >= r_m) : a_last_col;
    assign out_done     = out_col_last && row_last && (r_which || (r_m == '0));

    assign sw_a1  = r_unscr ? {r_j, 1'b0, i_stat.log_r} : {i_stat.pr, r_sec, r_k};
    assign sw_a2  = r_unscr ? {r_j, 1'b0, i_stat.log_c} : {i_stat.pc, r_sec, r_k};
    assign col_pc = {i_stat.pc, r_sec, r_k};
    assign col_j  = {r_j, r_sec, r_k};
    assign on_pivot = !r_sec && (r_k == i_stat.pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_sec   <= 1'b0;
            r_unscr <= 1'b0;
            r_which <= 1'b0;
            r_n     <= 3'd1;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_j     <= n_j;
            r_k     <= n_k;
            r_sec   <= n_sec;
            r_unscr <= n_unscr;
            r_which <= n_which;
            r_n     <= n_n;
            r_m     <= n_m;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_j     = r_j;
        n_k     = r_k;
        n_sec   = r_sec;
        n_unscr = r_unscr;
        n_which = r_which;
        n_n     = r_n;
        n_m     = r_m;

        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.wsrc    = W_RD;
        o_cmd.msrc    = MUL_SCALE;
        o_cmd.log_idx = r_step;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.wsrc   = W_LOAD;
                o_cmd.mem_we = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_n = (i_size == '0) ? 3'd1 :
                          (i_size > CNT_W'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : i_size;
                    n_m = (i_rhs > CNT_W'(MAX_RHS)) ? CNT_W'(MAX_RHS) : i_rhs;
                    o_cmd.used_clr = 1'b1;
                    o_cmd.srch_clr = 1'b1;
                    n_step  = '0;
                    n_j     = '0;
                    n_k     = '0;
                    n_sec   = 1'b0;
                    n_unscr = 1'b0;
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                o_cmd.raddr = {r_j, 1'b0, r_k};
                n_state     = ST_SRCH_CMP;
            end
            ST_SRCH_CMP: begin
                o_cmd.raddr    = {r_j, 1'b0, r_k};
                o_cmd.srch_cmp = 1'b1;
                n_state        = ST_SRCH_RD;
                if (!a_last_col) begin
                    n_k = k_inc[IDX_W-1:0];
                end else begin
                    n_k = '0;
                    if (!row_last) begin
                        n_j = j_inc[IDX_W-1:0];
                    end else begin
                        n_state = ST_PIV_LOG;
                    end
                end
            end
            ST_PIV_LOG: begin
                o_cmd.piv_commit = 1'b1;
                n_k     = '0;
                n_sec   = 1'b0;
                n_unscr = 1'b0;
                n_state = (i_stat.pr != i_stat.pc) ? ST_SW_RD1 : ST_PIV_RD;
            end
            ST_SW_RD1: begin
                o_cmd.raddr = sw_a1;
                n_state     = ST_SW_RD2;
            end
            ST_SW_RD2: begin
                o_cmd.raddr  = sw_a2;
                o_cmd.tmp_ld = 1'b1;
                n_state      = ST_SW_WR1;
            end
            ST_SW_WR1: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.waddr  = sw_a1;
                o_cmd.wsrc   = W_RD;
                n_state      = ST_SW_WR2;
            end
            ST_SW_WR2: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.waddr  = sw_a2;
                o_cmd.wsrc   = W_TMP;
                if (!r_unscr) begin
                    if (col_done) begin
                        n_state = ST_PIV_RD;
                    end else begin
                        n_k     = col_nk;
                        n_sec   = col_nsec;
                        n_state = ST_SW_RD1;
                    end
                end else if (!row_last) begin
                    n_j     = j_inc[IDX_W-1:0];
                    n_state = ST_SW_RD1;
                end else if (r_step == '0) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_which = 1'b0;
                    n_state = ST_OUT_RD;
                end else begin
                    n_step  = r_step - 2'd1;
                    n_state = ST_UN_CHK;
                end
            end
            ST_PIV_RD: begin
                o_cmd.raddr = {i_stat.pc, 1'b0, i_stat.pc};
                n_state     = ST_PIV_CHK;
            end
            ST_PIV_CHK: begin
                if (i_stat.big_zero) begin
                    n_state = ST_SING;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (!i_stat.div_busy) begin
                    n_k     = '0;
                    n_sec   = 1'b0;
                    n_state = ST_SC_RD;
                end
            end
            ST_SC_RD: begin
                o_cmd.raddr = col_pc;
                n_state     = ST_SC_MUL;
            end
            ST_SC_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.msrc    = MUL_SCALE;
                o_cmd.one_sel = on_pivot;
                n_state       = ST_SC_WR;
            end
            ST_SC_WR: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.waddr  = col_pc;
                o_cmd.wsrc   = W_PROD;
                if (col_done) begin
                    n_j     = '0;
                    n_state = ST_EL_ROW;
                end else begin
                    n_k     = col_nk;
                    n_sec   = col_nsec;
                    n_state = ST_SC_RD;
                end
            end
            ST_EL_ROW: begin
                if (r_j != i_stat.pc) begin
                    n_state = ST_EL_FRD;
                end else if (!row_last) begin
                    n_j = j_inc[IDX_W-1:0];
                end else if (!step_last) begin
                    o_cmd.srch_clr = 1'b1;
                    n_step  = step_inc[IDX_W-1:0];
                    n_j     = '0;
                    n_k     = '0;
                    n_sec   = 1'b0;
                    n_state = ST_SRCH_RD;
                end else begin
                    n_step  = IDX_W'(r_n - 3'd1);
                    n_state = ST_UN_CHK;
                end
            end
            ST_EL_FRD: begin
                o_cmd.raddr = {r_j, 1'b0, i_stat.pc};
                n_state     = ST_EL_FLD;
            end
            ST_EL_FLD: begin
                o_cmd.f_ld = 1'b1;
                n_k        = '0;
                n_sec      = 1'b0;
                n_state    = ST_EL_RD1;
            end
            ST_EL_RD1: begin
                o_cmd.raddr = col_pc;
                n_state     = ST_EL_RD2;
            end
            ST_EL_RD2: begin
                o_cmd.raddr  = col_j;
                o_cmd.mul_en = 1'b1;
                o_cmd.msrc   = MUL_ELIM;
                n_state      = ST_EL_WR;
            end
            ST_EL_WR: begin
                o_cmd.mem_we   = 1'b1;
                o_cmd.waddr    = col_j;
                o_cmd.wsrc     = W_DIFF;
                o_cmd.zero_old = on_pivot;
                if (!col_done) begin
                    n_k     = col_nk;
                    n_sec   = col_nsec;
                    n_state = ST_EL_RD1;
                end else if (!row_last) begin
                    n_j     = j_inc[IDX_W-1:0];
                    n_state = ST_EL_ROW;
                end else if (!step_last) begin
                    o_cmd.srch_clr = 1'b1;
                    n_step  = step_inc[IDX_W-1:0];
                    n_j     = '0;
                    n_k     = '0;
                    n_sec   = 1'b0;
                    n_state = ST_SRCH_RD;
                end else begin
                    n_step  = IDX_W'(r_n - 3'd1);
                    n_state = ST_UN_CHK;
                end
            end
            ST_UN_CHK: begin
                if (i_stat.log_r != i_stat.log_c) begin
                    n_unscr = 1'b1;
                    n_j     = '0;
                    n_state = ST_SW_RD1;
                end else if (r_step == '0) begin
                    n_j     = '0;
                    n_k     = '0;
                    n_which = 1'b0;
                    n_state = ST_OUT_RD;
                end else begin
                    n_step = r_step - 2'd1;
                end
            end
            ST_OUT_RD: begin
                o_cmd.raddr = {r_j, r_which, r_k};
                n_state     = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                o_cmd.raddr = {r_j, r_which, r_k};
                if (i_stat.out_free) begin
                    o_cmd.out_ld    = 1'b1;
                    o_cmd.out_which = r_which;
                    o_cmd.out_row   = r_j;
                    o_cmd.out_col   = r_k;
                    o_cmd.out_final = out_done;
                    n_state         = ST_OUT_RD;
                    if (out_done) begin
                        n_state = ST_IDLE;
                    end else if (!out_col_last) begin
                        n_k = k_inc[IDX_W-1:0];
                    end else if (!row_last) begin
                        n_k = '0;
                        n_j = j_inc[IDX_W-1:0];
                    end else begin
                        n_k     = '0;
                        n_j     = '0;
                        n_which = 1'b1;
                    end
                end
            end
            ST_SING: begin
                if (i_stat.out_free) begin
                    o_cmd.out_ld    = 1'b1;
                    o_cmd.out_sing  = 1'b1;
                    o_cmd.out_final = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/gauss_jordan_matrix_inverter.sv]
// Gauss-Jordan inverter with full pivoting on Q16.16 data, up to 4x4 with up to four
// right-hand-side columns. Load transactions are accepted back to back while idle. The
// transaction marked last starts a run on a register-file memory with one read and one
// write port and one shared multiplier: each elimination step runs a pivot search, a row
// swap where needed, the pivot reciprocal (a radix-2 divider, one bit per cycle), scaling
// of the pivot row and clearing of the other rows; the column unscramble then swaps the
// columns of each swapped pair, and each result is read and then loaded into the output
// register when the sink is ready. Loads are refused while a run is active; the last
// result may still wait in the output register when loads resume.
module gauss_jordan_matrix_inverter
    import gjmi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    gjmi_in_if.sink     i_in,
    gjmi_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic REG_SIZE = 1'b0;
    localparam logic REG_RHS  = 1'b1;

    logic [2:0] r_matrix_size;
    logic [2:0] r_rhs_columns;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= 3'd4;
            r_rhs_columns <= 3'd4;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_SIZE: r_matrix_size <= pwdata[2:0];
                REG_RHS:  r_rhs_columns <= pwdata[2:0];
                default:  r_matrix_size <= r_matrix_size;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = {29'd0, (paddr[2] == REG_RHS) ? r_rhs_columns : r_matrix_size};

    gjmi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.last),
        .o_in_ready (i_in.ready),
        .i_size     (r_matrix_size),
        .i_rhs      (r_rhs_columns),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gjmi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_opcode    (i_in.opcode),
        .i_row       (i_in.row),
        .i_col       (i_in.col),
        .i_value     (i_in.value),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_which     (o_out.which),
        .o_out_row   (o_out.out_row),
        .o_out_col   (o_out.out_col),
        .o_out_value (o_out.out_value),
        .o_singular  (o_out.singular),
        .o_final_res (o_out.final_res)
    );

endmodule

[dv/gjmi_checker.sv]
`timescale 1ns / 100ps

module gjmi_checker
    import gjmi_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    gjmi_in_if     i_in,
    gjmi_out_if    i_out,
    input  logic [2:0] i_order_reg,
    input  logic [2:0] i_rhs_reg,
    output int     o_errors,
    output int     o_pending
);

    typedef struct packed {
        logic        which;
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        singular;
        logic        final_res;
    } t_elem;

    t_elem elem_q[$];
    logic signed [31:0] mat_a[4][4];
    logic signed [31:0] mat_b[4][4];
    logic [1:0] col_used[4];
    int piv_r[4];
    int piv_c[4];

    function automatic logic signed [31:0] clip(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(logic signed [31:0] a, logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return clip(p >>> 16);
    endfunction

    function automatic longint absval(logic signed [31:0] x);
        longint v;
        v = x;
        return v < 0 ? -v : v;
    endfunction

    function automatic bit reduce(int n, int m);
        longint big;
        bit found;
        int pr, pc;
        logic signed [31:0] inv, t, f;
        for (int k = 0; k < 4; k++) col_used[k] = 0;
        for (int i = 0; i < n; i++) begin
            big = 0;
            found = 0;
            pr = 0;
            pc = 0;
            for (int j = 0; j < n; j++) begin
                if (col_used[j] == 1) continue;
                for (int k = 0; k < n; k++) begin
                    if (col_used[k] == 0) begin
                        if (absval(mat_a[j][k]) >= big) begin
                            big = absval(mat_a[j][k]);
                            pr = j;
                            pc = k;
                            found = 1;
                        end
                    end else if (col_used[k] > 1) begin
                        return 0;
                    end
                end
            end
            if (!found) return 0;
            if (col_used[pc] < 3) col_used[pc]++;
            if (pr != pc) begin
                for (int l = 0; l < n; l++) begin
                    t = mat_a[pr][l]; mat_a[pr][l] = mat_a[pc][l]; mat_a[pc][l] = t;
                end
                for (int l = 0; l < m; l++) begin
                    t = mat_b[pr][l]; mat_b[pr][l] = mat_b[pc][l]; mat_b[pc][l] = t;
                end
            end
            piv_r[i] = pr;
            piv_c[i] = pc;
            if (mat_a[pc][pc] == 0) return 0;
            inv = clip(64'sd4294967296 / longint'(mat_a[pc][pc]));
            mat_a[pc][pc] = Q_ONE;
            for (int l = 0; l < n; l++) mat_a[pc][l] = fx_mul(mat_a[pc][l], inv);
            for (int l = 0; l < m; l++) mat_b[pc][l] = fx_mul(mat_b[pc][l], inv);
            for (int r = 0; r < n; r++) begin
                if (r == pc) continue;
                f = mat_a[r][pc];
                mat_a[r][pc] = 0;
                for (int l = 0; l < n; l++)
                    mat_a[r][l] = clip(longint'(mat_a[r][l]) - fx_mul(mat_a[pc][l], f));
                for (int l = 0; l < m; l++)
                    mat_b[r][l] = clip(longint'(mat_b[r][l]) - fx_mul(mat_b[pc][l], f));
            end
        end
        for (int i = n - 1; i >= 0; i--) begin
            if (piv_r[i] != piv_c[i]) begin
                for (int k = 0; k < n; k++) begin
                    t = mat_a[k][piv_r[i]];
                    mat_a[k][piv_r[i]] = mat_a[k][piv_c[i]];
                    mat_a[k][piv_c[i]] = t;
                end
            end
        end
        return 1;
    endfunction

    task automatic predict_inverse(logic op, int r, int c, logic signed [31:0] v, logic lst);
        int n, m, total, cnt;
        t_elem e;
        if (!op) begin
            if (r < 4 && c < 4) mat_a[r][c] = v;
        end else begin
            if (r < 4 && c < 4) mat_b[r][c] = v;
        end
        if (!lst) return;
        n = i_order_reg;
        if (n < 1) n = 1;
        if (n > 4) n = 4;
        m = i_rhs_reg;
        if (m > 4) m = 4;
        if (!reduce(n, m)) begin
            e = '{1'b0, 3'd0, 3'd0, 32'd0, 1'b1, 1'b1};
            elem_q.push_back(e);
            return;
        end
        total = n * n + n * m;
        cnt = 0;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                cnt++;
                e = '{1'b0, 3'(i), 3'(j), mat_a[i][j], 1'b0, cnt == total};
                elem_q.push_back(e);
            end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < m; j++) begin
                cnt++;
                e = '{1'b1, 3'(i), 3'(j), mat_b[i][j], 1'b0, cnt == total};
                elem_q.push_back(e);
            end
    endtask

    assign o_pending = elem_q.size();

    always @(posedge i_clk) begin
        t_elem got, exp_e;
        if (!i_rst_n) begin
            o_errors = 0;
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++) begin
                    mat_a[i][j] = 0;
                    mat_b[i][j] = 0;
                end
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.which, i_out.out_row, i_out.out_col, i_out.out_value,
                        i_out.singular, i_out.final_res};
                if (elem_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                    o_errors++;
                end else begin
                    exp_e = elem_q.pop_front();
                    if (got !== exp_e) begin
                        $display("%0t: mismatch expected %h actual %h", $time, exp_e, got);
                        o_errors++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                predict_inverse(i_in.opcode, i_in.row, i_in.col, i_in.value, i_in.last);
        end
    end

endmodule

[dv/gauss_jordan_matrix_inverter_test.sv]
`timescale 1ns / 100ps

module gauss_jordan_matrix_inverter_test;
    import gjmi_pkg::*;

    localparam int REG_ORDER = 0;
    localparam int REG_RHS   = 1;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic [2:0]  order_reg;
    logic [2:0]  rhs_reg;
    int          errors;
    int          pending;
    int          items;

    gjmi_in_if  in_ch ();
    gjmi_out_if out_ch ();

    gauss_jordan_matrix_inverter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    gjmi_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_order_reg (order_reg),
        .i_rhs_reg   (rhs_reg),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial i_clk = 0;
    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // sink stall
    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else if ($urandom_range(0, 99) < 15) out_ch.ready <= ($urandom_range(0, 9) < 7);
        else if ($urandom_range(0, 99) < 3) out_ch.ready <= 1'b0;
        else out_ch.ready <= 1'b1;
    end

    task automatic reg_write(int idx, logic [2:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * idx);
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ORDER) order_reg <= val;
        else rhs_reg <= val;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic send(logic op, logic [2:0] r, logic [2:0] c, logic [31:0] v, logic lst);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.row    <= r;
        in_ch.col    <= c;
        in_ch.value  <= v;
        in_ch.last   <= lst;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items++;
    endtask

    function automatic logic [31:0] rand_elem(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            default: return 32'($signed($urandom_range(0, 600)) - 300);
        endcase
    endfunction

    // full matrix load; last goes on A(n-1,n-1) after every entry is written
    task automatic load_matrix(int n, int m, int mode, bit diag);
        logic [31:0] v;
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
                v = rand_elem(mode);
                if (diag && i == j) v = 32'(($urandom_range(0, 1) ? 1 : -1) * 6 * 65536);
                send(1'b0, 3'(i), 3'(j), v, 1'b0);
            end
        for (int i = 0; i < n; i++)
            for (int j = 0; j < m; j++)
                send(1'b1, 3'(i), 3'(j), rand_elem(mode), 1'b0);
        send(1'b0, 3'(n - 1), 3'(n - 1), rand_elem(mode), 1'b1);
    endtask

    initial begin
        int n, m, sel;
        items = 0;
        i_rst_n = 1'b0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        order_reg = 3'd4;
        rhs_reg = 3'd4;
        in_ch.valid = 0; in_ch.opcode = 0; in_ch.row = 0; in_ch.col = 0;
        in_ch.value = 0; in_ch.last = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: identity 4x4 with B extremes and ignored loads, then singular
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send(1'b0, 3'(i), 3'(j), i == j ? Q_ONE : Q_ZERO, 1'b0);
        send(1'b1, 3'd0, 3'd0, Q_MAX, 1'b0);
        send(1'b1, 3'd1, 3'd3, Q_MIN, 1'b0);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                if (!((i == 0 && j == 0) || (i == 1 && j == 3)))
                    send(1'b1, 3'(i), 3'(j), 32'(j - i), 1'b0);
        send(1'b0, 3'd7, 3'd7, 32'hffffffff, 1'b0);
        send(1'b1, 3'd2, 3'd5, 32'h12345678, 1'b1);
        drain();
        reg_write(REG_ORDER, 3'd2);
        reg_write(REG_RHS, 3'd0);
        send(1'b0, 3'd0, 3'd0, Q_ZERO, 1'b0);
        send(1'b0, 3'd0, 3'd1, Q_ZERO, 1'b0);
        send(1'b0, 3'd1, 3'd0, Q_ZERO, 1'b0);
        send(1'b0, 3'd1, 3'd1, Q_ZERO, 1'b1);
        drain();

        while (items < 340) begin
            sel = $urandom_range(0, 9);
            n = sel == 0 ? 7 : (sel == 1 ? 0 : $urandom_range(1, 5));
            m = sel == 2 ? 7 : $urandom_range(0, 4);
            reg_write(REG_ORDER, 3'(n));
            reg_write(REG_RHS, 3'(m));
            if (n < 1) n = 1;
            if (n > 4) n = 4;
            if (m > 4) m = 4;
            load_matrix(n, m, $urandom_range(0, 2), $urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                send($urandom_range(0, 1), 3'($urandom_range(4, 7)), 3'($urandom_range(0, 7)),
                     $urandom, 1'b0);
            drain();
        end

        drain();
        if (errors == 0) $display("[gauss_jordan_matrix_inverter] OK");
        else $display("[gauss_jordan_matrix_inverter] ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("[gauss_jordan_matrix_inverter] ERROR");
        $finish;
    end

endmodule

[files.f]
sv/gjmi_pkg.sv
sv/gjmi_in_if.sv
sv/gjmi_out_if.sv
sv/gjmi_div.sv
sv/gjmi_dp.sv
sv/gjmi_ctrl.sv
sv/gauss_jordan_matrix_inverter.sv
dv/gjmi_checker.sv
dv/gauss_jordan_matrix_inverter_test.sv
